@@ rtl/acp_pkg.sv @@
// Package for the accumulator CPU execute block: opcodes, flag codes, result struct.
`timescale 1ns / 1ps

package acp_pkg;

    typedef enum logic [4:0] {
        OP_NOP  = 5'h00,
        OP_STA  = 5'h01,
        OP_LDA  = 5'h02,
        OP_ADD  = 5'h03,
        OP_OR   = 5'h04,
        OP_AND  = 5'h05,
        OP_NOT  = 5'h06,
        OP_SUB  = 5'h07,
        OP_JMP  = 5'h08,
        OP_JN   = 5'h09,
        OP_JZ   = 5'h0A,
        OP_LDI  = 5'h0B,
        OP_SHL  = 5'h0C,
        OP_SHR  = 5'h0D,
        OP_ADDU = 5'h0E,
        OP_SUBU = 5'h0F,
        OP_IN   = 5'h10,
        OP_OUT  = 5'h11,
        OP_HALT = 5'h1F
    } opcode_t;

    localparam logic [1:0] FLAG_NONE = 2'd0;
    localparam logic [1:0] FLAG_NEG  = 2'd1;
    localparam logic [1:0] FLAG_ZERO = 2'd2;

    localparam logic [7:0] SHIFT_LIMIT = 8'd8;

    typedef struct packed {
        logic [7:0] acc;
        logic [1:0] flag;
        logic       halt;
        logic       jump;
        logic [7:0] target;
        logic       out_valid;
        logic [7:0] out_value;
        logic       mem_we;
    } exec_res_t;

endpackage

@@ rtl/accumulator_cpu_execute.sv @@
// Stages: operand fetch, then execute; the data memory read is issued at input accept.
// Throughput: one instruction per cycle while the result output is not stalled by m_ready.
// STA write-back is forwarded to a same-address read accepted in the same cycle.
// Reset (aresetn low, synchronous) clears accumulator, flag, halt and all memory valid bits,
// so the data memory reads as zero immediately after reset with no clearing pass.
`timescale 1ns / 1ps

module accumulator_cpu_execute
    import acp_pkg::*;
#(
    parameter int MEM_DEPTH = 256
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_op,
    input  logic [7:0] s_operand,
    input  logic [7:0] s_in_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_acc,
    output logic       m_jump_taken,
    output logic [7:0] m_jump_target,
    output logic       m_out_valid,
    output logic [7:0] m_out_value,
    output logic       m_halted,
    output logic [1:0] m_branch_flag
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(MEM_DEPTH);

    logic [7:0]          mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] mem_ok_reg;

    logic       s1_valid_reg;
    logic [4:0] s1_op_reg;
    logic [7:0] s1_operand_reg;
    logic [7:0] s1_in_value_reg;
    logic [7:0] s1_mem_reg;
    logic       s1_mem_ok_reg;

    logic [7:0] acc_reg;
    logic [1:0] flag_reg;
    logic       halt_reg;

    logic       m_valid_reg;
    logic [7:0] m_acc_reg;
    logic       m_jump_reg;
    logic [7:0] m_target_reg;
    logic       m_out_valid_reg;
    logic [7:0] m_out_value_reg;
    logic       m_halted_reg;
    logic [1:0] m_flag_reg;

    logic          s_accept;
    logic          advance;
    logic          rd_in_range;
    logic          wr_in_range;
    logic          mem_wr;
    logic          fwd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    mem_byte;
    exec_res_t     res;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign rd_in_range = ({1'b0, s_operand} < DEPTH_LIM);
    assign wr_in_range = ({1'b0, s1_operand_reg} < DEPTH_LIM);
    assign rd_addr     = s_operand[AW-1:0];
    assign wr_addr     = s1_operand_reg[AW-1:0];
    assign mem_wr      = advance && res.mem_we && wr_in_range;
    // write-back of the executing STA hits the address being fetched this cycle
    assign fwd         = mem_wr && (s1_operand_reg == s_operand);
    assign mem_byte    = s1_mem_ok_reg ? s1_mem_reg : 8'd0;

    acp_exec u_exec (
        .op       (s1_op_reg),
        .operand  (s1_operand_reg),
        .in_value (s1_in_value_reg),
        .mem_byte (mem_byte),
        .acc      (acc_reg),
        .flag     (flag_reg),
        .halt     (halt_reg),
        .res      (res)
    );

    // data memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_addr] <= acc_reg;
        end
        if (s_accept) begin
            s1_mem_reg <= fwd ? acc_reg : mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_ok_reg    <= '0;
            s1_mem_ok_reg <= 1'b0;
        end else begin
            if (mem_wr) begin
                mem_ok_reg[wr_addr] <= 1'b1;
            end
            if (s_accept) begin
                s1_mem_ok_reg <= fwd || (rd_in_range && mem_ok_reg[rd_addr]);
            end
        end
    end

    // fetch stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg       <= s_op;
            s1_operand_reg  <= s_operand;
            s1_in_value_reg <= s_in_value;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= 8'd0;
            flag_reg <= FLAG_NONE;
            halt_reg <= 1'b0;
        end else if (advance) begin
            acc_reg  <= res.acc;
            flag_reg <= res.flag;
            halt_reg <= res.halt;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_acc_reg       <= res.acc;
            m_jump_reg      <= res.jump;
            m_target_reg    <= res.target;
            m_out_valid_reg <= res.out_valid;
            m_out_value_reg <= res.out_value;
            m_halted_reg    <= res.halt;
            m_flag_reg      <= res.flag;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_acc         = m_acc_reg;
    assign m_jump_taken  = m_jump_reg;
    assign m_jump_target = m_target_reg;
    assign m_out_valid   = m_out_valid_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_halted      = m_halted_reg;
    assign m_branch_flag = m_flag_reg;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt latch cleared while running");

    a_no_jump_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_jump_reg |-> m_target_reg == 8'd0)
        else $error("jump target set without a jump");

    a_out_is_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_out_valid_reg |-> m_out_value_reg == m_acc_reg)
        else $error("OUT value differs from accumulator");

    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_halted_reg |-> !m_out_valid_reg && !m_jump_reg)
        else $error("halted result reports jump or output");

    a_stall_holds_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(acc_reg))
        else $error("accumulator changed during result stall");
`endif

endmodule

@@ rtl/acp_exec.sv @@
// Instruction execute logic: accumulator, flag and halt update for one instruction.
`timescale 1ns / 1ps

module acp_exec
    import acp_pkg::*;
(
    input  logic [4:0] op,
    input  logic [7:0] operand,
    input  logic [7:0] in_value,
    input  logic [7:0] mem_byte,
    input  logic [7:0] acc,
    input  logic [1:0] flag,
    input  logic       halt,
    output exec_res_t  res
);

    logic [7:0] shl_val;
    logic [7:0] shr_val;

    assign shl_val = (mem_byte >= SHIFT_LIMIT) ? 8'd0 : 8'(acc << mem_byte[2:0]);
    assign shr_val = (mem_byte >= SHIFT_LIMIT) ? 8'd0 : 8'(acc >> mem_byte[2:0]);

    always_comb begin
        res           = '0;
        res.acc       = acc;
        res.flag      = flag;
        res.halt      = halt;
        if (!halt) begin
            case (op)
                OP_STA:  res.mem_we = 1'b1;
                OP_LDA:  res.acc = mem_byte;
                OP_ADD, OP_ADDU: res.acc = acc + mem_byte;
                OP_SUB, OP_SUBU: res.acc = acc - mem_byte;
                OP_OR:   res.acc = acc | mem_byte;
                OP_AND:  res.acc = acc & mem_byte;
                OP_NOT:  res.acc = ~acc;
                OP_JMP:  res.jump = 1'b1;
                OP_JN: begin
                    res.flag = acc[7] ? FLAG_NEG : FLAG_NONE;
                    res.jump = acc[7];
                end
                OP_JZ: begin
                    res.flag = (acc == 8'd0) ? FLAG_ZERO : FLAG_NONE;
                    res.jump = (acc == 8'd0);
                end
                OP_LDI:  res.acc = operand;
                OP_SHL:  res.acc = shl_val;
                OP_SHR:  res.acc = shr_val;
                OP_IN:   res.acc = in_value;
                OP_OUT: begin
                    res.out_valid = 1'b1;
                    res.out_value = acc;
                end
                OP_HALT: res.halt = 1'b1;
                default: ;
            endcase
        end
        res.target = res.jump ? operand : 8'd0;
    end

endmodule

@@ dv/accumulator_cpu_execute_tb.sv @@
// Self-checking testbench for the accumulator CPU execute stage with a shadow machine model.
`timescale 1ns / 1ps

module accumulator_cpu_execute_tb;
    import acp_pkg::*;

    localparam logic [4:0] OP_DUMP     = 5'h12;  // memory dump code, executes as NOP
    localparam logic [4:0] OP_SPARE_HI = 5'h1E;  // last unassigned code below HALT
    localparam int RANDOM_ITEMS     = 1500;
    localparam int LONG_HOLD_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 16;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] operand;
        logic [7:0] in_value;
    } instr_t;

    typedef struct packed {
        logic [7:0] acc;
        logic       jump_taken;
        logic [7:0] jump_target;
        logic       out_valid;
        logic [7:0] out_value;
        logic       halted;
        logic [1:0] branch_flag;
    } retire_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [4:0] s_op       = '0;
    logic [7:0] s_operand  = '0;
    logic [7:0] s_in_value = '0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_acc;
    logic       m_jump_taken;
    logic [7:0] m_jump_target;
    logic       m_out_valid;
    logic [7:0] m_out_value;
    logic       m_halted;
    logic [1:0] m_branch_flag;

    accumulator_cpu_execute dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_operand     (s_operand),
        .s_in_value    (s_in_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_acc         (m_acc),
        .m_jump_taken  (m_jump_taken),
        .m_jump_target (m_jump_target),
        .m_out_valid   (m_out_valid),
        .m_out_value   (m_out_value),
        .m_halted      (m_halted),
        .m_branch_flag (m_branch_flag)
    );

    instr_t  program_q[$];
    retire_t retire_q[$];

    // shadow machine state
    logic [7:0] shadow_mem [256];
    logic [7:0] shadow_acc;
    logic [1:0] shadow_flag;
    logic       shadow_halt;

    int mismatch_count = 0;
    int accepted_count = 0;
    int retired_count  = 0;
    int taken_jumps    = 0;
    int out_bytes      = 0;
    int cycle_count    = 0;
    logic in_taken     = 1'b0;
    int send_gap       = 0;
    int recv_stall     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones; none at all in quiet stretches
    function automatic int draw_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_instr(input logic [4:0] op, input logic [7:0] operand,
                              input logic [7:0] in_value);
        instr_t ins;
        ins.op       = op;
        ins.operand  = operand;
        ins.in_value = in_value;
        program_q.push_back(ins);
    endtask

    task automatic execute_instr(input instr_t ins, output retire_t res);
        logic [7:0] m;
        logic [7:0] a;
        res = '0;
        if (!shadow_halt) begin
            m = shadow_mem[ins.operand];
            a = shadow_acc;
            case (ins.op)
                OP_STA:          shadow_mem[ins.operand] = a;
                OP_LDA:          a = m;
                OP_ADD, OP_ADDU: a = a + m;
                OP_SUB, OP_SUBU: a = a - m;
                OP_OR:           a = a | m;
                OP_AND:          a = a & m;
                OP_NOT:          a = ~a;
                OP_JMP:          res.jump_taken = 1'b1;
                OP_JN: begin
                    shadow_flag = a[7] ? FLAG_NEG : FLAG_NONE;
                    res.jump_taken = (shadow_flag == FLAG_NEG);
                end
                OP_JZ: begin
                    shadow_flag = (a == 8'h00) ? FLAG_ZERO : FLAG_NONE;
                    res.jump_taken = (shadow_flag == FLAG_ZERO);
                end
                OP_LDI:          a = ins.operand;
                OP_SHL:          a = (m >= SHIFT_LIMIT) ? 8'h00 : (a << m[2:0]);
                OP_SHR:          a = (m >= SHIFT_LIMIT) ? 8'h00 : (a >> m[2:0]);
                OP_IN:           a = ins.in_value;
                OP_OUT:          res.out_valid = 1'b1;
                OP_HALT:         shadow_halt = 1'b1;
                default: ;
            endcase
            shadow_acc = a;
        end
        res.acc         = shadow_acc;
        res.jump_target = res.jump_taken ? ins.operand : 8'h00;
        res.out_value   = res.out_valid ? shadow_acc : 8'h00;
        res.halted      = shadow_halt;
        res.branch_flag = shadow_flag;
        if (res.jump_taken)
            taken_jumps++;
        if (res.out_valid)
            out_bytes++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected 0x%02h actual 0x%02h",
                     $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // One random burst: a lone instruction or a short well-formed program fragment.
    task automatic queue_random_burst(output int pushed);
        int kind;
        int n;
        logic [7:0] addr;
        logic [7:0] amt;
        kind   = $urandom_range(0, 99);
        pushed = 0;
        if (kind < 40) begin
            if ($urandom_range(0, 99) < 85)
                push_instr(5'($urandom_range(OP_NOP, OP_OUT)), pick_addr(), rand_byte());
            else
                push_instr(5'($urandom_range(OP_DUMP, OP_SPARE_HI)), rand_byte(), rand_byte());
            pushed = 1;
        end else if (kind < 70) begin
            addr = pick_addr();
            if ($urandom_range(0, 1))
                push_instr(OP_LDI, rand_byte(), rand_byte());
            else
                push_instr(OP_IN, pick_addr(), rand_byte());
            push_instr(OP_STA, addr, rand_byte());
            push_instr(OP_IN, rand_byte(), rand_byte());
            pushed = 3;
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0: push_instr(OP_ADD, addr, rand_byte());
                    1: push_instr(OP_SUB, addr, rand_byte());
                    2: push_instr(OP_ADDU, addr, rand_byte());
                    3: push_instr(OP_SUBU, pick_addr(), rand_byte());
                    4: push_instr(OP_OR, pick_addr(), rand_byte());
                    default: push_instr(OP_AND, addr, rand_byte());
                endcase
            end
            case ($urandom_range(0, 2))
                0: push_instr(OP_JN, rand_byte(), rand_byte());
                1: push_instr(OP_JZ, rand_byte(), rand_byte());
                default: push_instr(OP_OUT, pick_addr(), rand_byte());
            endcase
            pushed += n + 1;
        end else if (kind < 90) begin
            addr = pick_addr();
            amt  = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(0, 10));
            push_instr(OP_LDI, amt, rand_byte());
            push_instr(OP_STA, addr, rand_byte());
            push_instr(OP_IN, rand_byte(), rand_byte());
            push_instr($urandom_range(0, 1) ? OP_SHL : OP_SHR, addr, rand_byte());
            push_instr(OP_OUT, rand_byte(), rand_byte());
            pushed = 5;
        end else begin
            // zero and negative accumulators for the conditional jumps
            case ($urandom_range(0, 2))
                0: push_instr(OP_LDI, 8'h00, rand_byte());
                1: push_instr(OP_LDI, 8'($urandom_range(8'h80, 8'hFF)), rand_byte());
                default: push_instr(OP_LDI, rand_byte(), rand_byte());
            endcase
            push_instr(OP_JZ, rand_byte(), rand_byte());
            push_instr(OP_JN, rand_byte(), rand_byte());
            pushed = 3;
        end
    endtask

    // Driver: presents the next pending instruction at the falling edge.
    always @(negedge aclk) begin : drive_instr
        instr_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (program_q.size() > 0) begin
                nxt = program_q.pop_front();
                s_op       <= nxt.op;
                s_operand  <= nxt.operand;
                s_in_value <= nxt.in_value;
                s_valid    <= 1'b1;
                send_gap = draw_gap(((accepted_count / 200) % 4) == 1);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off to back the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            cycle_count++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && accepted_count >= LONG_HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_stall = draw_gap(((cycle_count / 256) % 4) == 2);
            end
        end
    end

    // Monitor: predicts on each input transaction, checks each result transaction.
    always @(posedge aclk) begin : observe
        retire_t want;
        retire_t got;
        if (!aresetn) begin
            in_taken <= 1'b0;
            for (int i = 0; i < 256; i++)
                shadow_mem[i] = 8'h00;
            shadow_acc  = 8'h00;
            shadow_flag = FLAG_NONE;
            shadow_halt = 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                execute_instr('{s_op, s_operand, s_in_value}, want);
                retire_q.push_back(want);
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                got = '{m_acc, m_jump_taken, m_jump_target, m_out_valid, m_out_value,
                        m_halted, m_branch_flag};
                if (retire_q.size() == 0) begin
                    $display("%0t: result transaction with nothing outstanding, actual %h",
                             $time, got);
                    mismatch_count++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("acc", want.acc, got.acc);
                    check_field("jump_taken", 8'(want.jump_taken), 8'(got.jump_taken));
                    check_field("jump_target", want.jump_target, got.jump_target);
                    check_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
                    check_field("out_value", want.out_value, got.out_value);
                    check_field("halted", 8'(want.halted), 8'(got.halted));
                    check_field("branch_flag", 8'(want.branch_flag), 8'(got.branch_flag));
                    retired_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int random_count;
        int n;
        random_count = 0;

        // directed: operand extremes, every opcode but NOP and HALT, wraps, shift limits, flags
        push_instr(OP_LDI,  8'hFF, 8'h00);
        push_instr(OP_OUT,  8'h00, 8'h00);
        push_instr(OP_STA,  8'h00, 8'h00);
        push_instr(OP_JN,   8'hAA, 8'h00);
        push_instr(OP_JZ,   8'h55, 8'h00);
        push_instr(OP_NOT,  8'h00, 8'h00);
        push_instr(OP_JZ,   8'hFF, 8'h00);
        push_instr(OP_JMP,  8'h00, 8'h00);  // flag must hold at zero
        push_instr(OP_LDA,  8'h00, 8'h00);
        push_instr(OP_ADD,  8'h00, 8'h00);  // 0xFF + 0xFF wraps
        push_instr(OP_SUBU, 8'h00, 8'h00);  // borrow wraps
        push_instr(OP_ADDU, 8'hFF, 8'h00);
        push_instr(OP_SUB,  8'h80, 8'h00);
        push_instr(OP_LDI,  8'h07, 8'h00);
        push_instr(OP_STA,  8'h01, 8'h00);
        push_instr(OP_LDI,  8'h08, 8'h00);
        push_instr(OP_STA,  8'h02, 8'h00);
        push_instr(OP_IN,   8'h00, 8'h81);
        push_instr(OP_SHL,  8'h01, 8'h00);  // shift by 7
        push_instr(OP_SHR,  8'h01, 8'h00);
        push_instr(OP_IN,   8'h00, 8'hFF);
        push_instr(OP_SHL,  8'h02, 8'h00);  // shift by 8 clears
        push_instr(OP_OR,   8'h00, 8'h00);
        push_instr(OP_AND,  8'h01, 8'h00);
        push_instr(OP_DUMP, 8'h00, 8'h00);  // dump code acts as NOP
        push_instr(OP_SPARE_HI, 8'hFF, 8'hFF);

        while (random_count < RANDOM_ITEMS) begin
            queue_random_burst(n);
            random_count += n;
        end

        // halt near the end, then confirm later instructions are ignored
        push_instr(OP_HALT, rand_byte(), rand_byte());
        push_instr(OP_OUT, rand_byte(), rand_byte());
        push_instr(OP_JMP, rand_byte(), rand_byte());
        push_instr(OP_IN, rand_byte(), rand_byte());
        push_instr(OP_HALT, rand_byte(), rand_byte());
        repeat (4) begin
            queue_random_burst(n);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (program_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (retire_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Executed %0d instructions, checked %0d results (%0d taken jumps, %0d OUT bytes)",
                 accepted_count, retired_count, taken_jumps, out_bytes);
        $display("Mix covered all opcodes, unassigned codes, shifts past 7, a long output stall, halt");
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
